// ===== design/distance_vector_route_table_core_defines.svh =====
// Assertion macros shared by the route table RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_CORE_DEFINES_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DVRT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DVRT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DVRT_ASSERT(label, clk, rst_n, prop, msg)
`define DVRT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== design/dvrt_pkg.sv =====
// Shared types and constants of the distance-vector route table.
// No dependencies.
package dvrt_pkg;

    localparam int IN_W  = 136;
    localparam int IN_USER_W = 2;
    localparam int OUT_W = 72;
    localparam int USER_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [4:0] METRIC_INF = 5'd16;

    localparam logic [1:0] OP_UPDATE    = 2'd0;
    localparam logic [1:0] OP_AGING     = 2'd1;
    localparam logic [1:0] OP_ADVERTISE = 2'd2;

    localparam logic [1:0] ST_FREE    = 2'd0;
    localparam logic [1:0] ST_ACTIVE  = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    localparam logic [1:0] CFG_OWN_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_ROUTE_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_PURGE_DELAY = 2'd2;

    localparam logic [15:0] RESET_ROUTE_TIMEOUT = 16'd180;
    localparam logic [15:0] RESET_PURGE_DELAY = 16'd120;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_ALLOC,
        S_FINAL
    } t_state;

    typedef struct packed {
        logic load_item;
        logic inc_idx;
        logic eval;
        logic alloc;
        logic push_adv;
        logic push_final;
    } t_ctrl_cmd;

    typedef struct packed {
        logic [1:0] opcode;
        logic       own_hit;
        logic       idx_last;
        logic       match;
        logic       adv_hit;
        logic       have_held;
        logic       out_free;
    } t_dp_stat;

endpackage

// ===== design/dvrt_ctrl.sv =====
// Sequencer of the route table: walks the entries and orders result transfers.
// Depends on dvrt_pkg and the assertion macro header.
`include "distance_vector_route_table_core_defines.svh"
module dvrt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dvrt_pkg::t_dp_stat  i_stat,
    output dvrt_pkg::t_ctrl_cmd o_cmd
);
    import dvrt_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                case (i_stat.opcode)
                    OP_UPDATE: begin
                        if (i_stat.own_hit) begin
                            n_state = S_FINAL;
                        end else if (i_stat.match) begin
                            o_cmd.eval = 1'b1;
                            n_state = S_FINAL;
                        end else if (i_stat.idx_last) begin
                            o_cmd.eval = 1'b1;
                            n_state = S_ALLOC;
                        end else begin
                            o_cmd.eval = 1'b1;
                            o_cmd.inc_idx = 1'b1;
                            n_state = S_READ;
                        end
                    end
                    OP_AGING, OP_ADVERTISE: begin
                        // hold while an older route waits for the output slot
                        if (!(i_stat.opcode == OP_ADVERTISE && i_stat.adv_hit &&
                              i_stat.have_held && !i_stat.out_free)) begin
                            o_cmd.eval = 1'b1;
                            o_cmd.push_adv = (i_stat.opcode == OP_ADVERTISE) &&
                                             i_stat.adv_hit && i_stat.have_held;
                            if (i_stat.idx_last) begin
                                n_state = S_FINAL;
                            end else begin
                                o_cmd.inc_idx = 1'b1;
                                n_state = S_READ;
                            end
                        end
                    end
                    default: begin
                        n_state = S_FINAL;
                    end
                endcase
            end
            S_ALLOC: begin
                o_cmd.alloc = 1'b1;
                n_state = S_FINAL;
            end
            S_FINAL: begin
                if (i_stat.out_free) begin
                    o_cmd.push_final = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `DVRT_NEVER(a_one_push, i_clk, i_rst_n, o_cmd.push_adv && o_cmd.push_final, "double push")
    `DVRT_ASSERT(a_push_free, i_clk, i_rst_n, (o_cmd.push_adv || o_cmd.push_final) |-> i_stat.out_free, "push into full output")
    `DVRT_ASSERT(a_load_read, i_clk, i_rst_n, o_cmd.load_item |=> (r_state == S_READ), "load did not start sweep")
    `DVRT_ASSERT(a_alloc_once, i_clk, i_rst_n, (r_state == S_ALLOC) |=> (r_state == S_FINAL), "alloc not followed by result")

endmodule

// ===== design/dvrt_datapath.sv =====
// Route table storage, per-entry evaluation and output register.
// Depends on dvrt_pkg; commanded by dvrt_ctrl.
module dvrt_datapath #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dvrt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dvrt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [dvrt_pkg::IN_USER_W-1:0] i_op,
    input  logic [dvrt_pkg::IN_W-1:0]      i_item,
    input  dvrt_pkg::t_ctrl_cmd            i_cmd,
    output dvrt_pkg::t_dp_stat             o_stat,
    output logic                           o_tvalid,
    input  logic                           i_tready,
    output logic [dvrt_pkg::OUT_W-1:0]     o_tdata,
    output logic [dvrt_pkg::USER_W-1:0]    o_tuser,
    output logic                           o_tlast
);
    import dvrt_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // configuration
    logic [31:0] r_own;
    logic [15:0] r_rt, r_pd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own <= '0;
            r_rt  <= RESET_ROUTE_TIMEOUT;
            r_pd  <= RESET_PURGE_DELAY;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_OWN_ADDRESS:   r_own <= i_cfg_data;
                CFG_ROUTE_TIMEOUT: r_rt <= i_cfg_data[15:0];
                CFG_PURGE_DELAY:   r_pd <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // captured item
    logic [1:0]  r_op;
    logic [31:0] r_peer, r_dest, r_now;
    logic [4:0]  r_m;
    logic [32:0] w_sum;
    logic [4:0]  w_m;

    assign w_sum = {1'b0, i_item[95:64]} + {25'd0, i_item[103:96]};
    assign w_m = (w_sum > 33'd16) ? METRIC_INF : w_sum[4:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op   <= i_op;
            r_peer <= i_item[31:0];
            r_dest <= i_item[63:32];
            r_m    <= w_m;
            r_now  <= i_item[135:104];
        end
    end

    // entry index and status flops
    logic [IW-1:0] r_idx, r_free_idx;
    logic          r_free_found;
    logic [1:0]    r_status [TABLE_DEPTH];
    logic [1:0]    w_cur_st;

    assign w_cur_st = r_status[r_idx];

    // entry memories
    logic [31:0] m_dest [TABLE_DEPTH];
    logic [31:0] m_gw [TABLE_DEPTH];
    logic [4:0]  m_metric [TABLE_DEPTH];
    logic [31:0] m_exp [TABLE_DEPTH];
    logic [31:0] m_purge [TABLE_DEPTH];
    logic [31:0] r_rd_dest, r_rd_gw, r_rd_exp, r_rd_purge;
    logic [4:0]  r_rd_metric;

    always_ff @(posedge i_clk) begin
        r_rd_dest   <= m_dest[r_idx];
        r_rd_gw     <= m_gw[r_idx];
        r_rd_metric <= m_metric[r_idx];
        r_rd_exp    <= m_exp[r_idx];
        r_rd_purge  <= m_purge[r_idx];
    end

    // per-entry evaluation
    logic          w_same_gw, w_match, w_adv_hit, w_free_here;
    logic [31:0]   w_exp_new, w_purge_new;
    logic [31:0]   w_left, w_half;
    logic          we_dest, we_gw, we_metric, we_exp, we_purge, we_st, w_chg;
    logic [4:0]    wd_metric;
    logic [1:0]    wd_st;
    logic [IW-1:0] w_waddr;
    logic [31:0]   w_age_t;
    logic          w_age_tv;
    logic [4:0]    w_adv_metric;

    assign w_same_gw = (r_rd_gw == r_peer);
    assign w_match = (w_cur_st != ST_FREE) && (r_rd_dest == r_dest);
    assign w_adv_hit = (w_cur_st != ST_FREE) && (r_rd_dest != r_peer);
    assign w_free_here = (w_cur_st == ST_FREE);
    assign w_exp_new = r_now + {16'd0, r_rt};
    assign w_purge_new = r_now + {16'd0, r_pd};
    assign w_left = r_rd_exp - r_now;
    assign w_half = {17'd0, r_rt[15:1]};
    assign w_adv_metric = w_same_gw ? METRIC_INF : r_rd_metric;
    assign w_waddr = i_cmd.alloc ? r_free_idx : r_idx;

    always_comb begin
        we_dest = 1'b0;
        we_gw = 1'b0;
        we_metric = 1'b0;
        we_exp = 1'b0;
        we_purge = 1'b0;
        we_st = 1'b0;
        wd_metric = r_m;
        wd_st = ST_ACTIVE;
        w_chg = 1'b0;
        w_age_t = r_rd_exp;
        w_age_tv = 1'b0;
        if (i_cmd.alloc) begin
            if (r_free_found && r_m != METRIC_INF) begin
                we_dest = 1'b1;
                we_gw = 1'b1;
                we_metric = 1'b1;
                we_exp = 1'b1;
                we_st = 1'b1;
                w_chg = 1'b1;
            end
        end else if (i_cmd.eval) begin
            case (r_op)
                OP_UPDATE: begin
                    if (w_match) begin
                        if (r_m == METRIC_INF) begin
                            if (w_same_gw && r_rd_metric != METRIC_INF) begin
                                we_st = 1'b1;
                                wd_st = ST_TIMEOUT;
                                we_metric = 1'b1;
                                wd_metric = METRIC_INF;
                                we_purge = 1'b1;
                                w_chg = 1'b1;
                            end
                        end else if ((w_same_gw || r_rd_metric >= r_m) &&
                                     (r_rd_metric > r_m || w_same_gw ||
                                      $signed(w_left) < $signed(w_half))) begin
                            we_st = 1'b1;
                            we_gw = 1'b1;
                            we_metric = 1'b1;
                            we_exp = 1'b1;
                            w_chg = (r_rd_metric != r_m) || !w_same_gw;
                        end
                    end
                end
                OP_AGING: begin
                    if (w_cur_st == ST_ACTIVE) begin
                        if ($signed(r_now - r_rd_exp) >= 0) begin
                            we_st = 1'b1;
                            wd_st = ST_TIMEOUT;
                            we_metric = 1'b1;
                            wd_metric = METRIC_INF;
                            we_purge = 1'b1;
                            w_chg = 1'b1;
                            w_age_t = w_purge_new;
                        end else begin
                            w_age_t = r_rd_exp;
                        end
                        w_age_tv = 1'b1;
                    end else if (w_cur_st == ST_TIMEOUT) begin
                        if ($signed(r_now - r_rd_purge) > 0) begin
                            we_st = 1'b1;
                            wd_st = ST_FREE;
                            w_chg = 1'b1;
                        end else begin
                            w_age_t = r_rd_purge;
                            w_age_tv = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_dest) m_dest[w_waddr] <= r_dest;
        if (we_gw) m_gw[w_waddr] <= r_peer;
        if (we_metric) m_metric[w_waddr] <= wd_metric;
        if (we_exp) m_exp[w_waddr] <= w_exp_new;
        if (we_purge) m_purge[w_waddr] <= w_purge_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                r_status[k] <= ST_FREE;
            end
        end else if (we_st) begin
            r_status[w_waddr] <= wd_st;
        end
    end

    // sweep state and accumulators
    logic        r_chg, r_have, r_held_valid;
    logic [31:0] r_best, r_held_dest;
    logic [4:0]  r_held_metric;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_free_idx <= '0;
            r_free_found <= 1'b0;
            r_chg <= 1'b0;
            r_have <= 1'b0;
            r_held_valid <= 1'b0;
            r_best <= '0;
            r_held_dest <= '0;
            r_held_metric <= '0;
        end else if (i_cmd.load_item) begin
            r_idx <= '0;
            r_free_found <= 1'b0;
            r_chg <= 1'b0;
            r_have <= 1'b0;
            r_held_valid <= 1'b0;
            r_best <= '0;
        end else begin
            if (i_cmd.inc_idx) begin
                r_idx <= r_idx + 1'b1;
            end
            if (w_chg) begin
                r_chg <= 1'b1;
            end
            if (i_cmd.eval && r_op == OP_UPDATE && w_free_here && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx <= r_idx;
            end
            if (w_age_tv && (!r_have || $signed(r_best - w_age_t) > 0)) begin
                r_best <= w_age_t;
                r_have <= 1'b1;
            end
            if (i_cmd.eval && r_op == OP_ADVERTISE && w_adv_hit) begin
                r_held_valid <= 1'b1;
                r_held_dest <= r_rd_dest;
                r_held_metric <= w_adv_metric;
            end
        end
    end

    // output register
    logic r_o_valid, r_o_last, r_o_chg, r_o_rv, r_o_dv;
    logic [31:0] r_o_dest, r_o_nd;
    logic [4:0]  r_o_metric;
    logic w_out_free;

    assign w_out_free = !r_o_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.push_adv || i_cmd.push_final) begin
            r_o_valid <= 1'b1;
        end else if (i_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_adv) begin
            r_o_chg <= 1'b0;
            r_o_rv <= 1'b1;
            r_o_dest <= r_held_dest;
            r_o_metric <= r_held_metric;
            r_o_dv <= 1'b0;
            r_o_nd <= '0;
            r_o_last <= 1'b0;
        end else if (i_cmd.push_final) begin
            r_o_chg <= '0;
            r_o_rv <= '0;
            r_o_dest <= '0;
            r_o_metric <= '0;
            r_o_dv <= '0;
            r_o_nd <= '0;
            r_o_last <= 1'b1;
            case (r_op)
                OP_UPDATE: r_o_chg <= r_chg;
                OP_AGING: begin
                    r_o_chg <= r_chg;
                    r_o_dv <= r_have;
                    r_o_nd <= r_best;
                end
                OP_ADVERTISE: begin
                    r_o_rv <= r_held_valid;
                    r_o_dest <= r_held_valid ? r_held_dest : 32'd0;
                    r_o_metric <= r_held_valid ? r_held_metric : 5'd0;
                end
                default: ;
            endcase
        end
    end

    assign o_tvalid = r_o_valid;
    assign o_tdata = {2'b00, r_o_nd, r_o_metric, r_o_dest, r_o_chg};
    assign o_tuser = {r_o_dv, r_o_rv};
    assign o_tlast = r_o_last;

    assign o_stat.opcode = r_op;
    assign o_stat.own_hit = (r_dest == r_own);
    assign o_stat.idx_last = (r_idx == IW'(TABLE_DEPTH - 1));
    assign o_stat.match = w_match;
    assign o_stat.adv_hit = w_adv_hit;
    assign o_stat.have_held = r_held_valid;
    assign o_stat.out_free = w_out_free;

endmodule

// ===== design/distance_vector_route_table_core.sv =====
// Distance-vector route table, top level.
// Joins dvrt_ctrl and dvrt_datapath; depends on dvrt_pkg.
//
// Usage:
//   Items enter on the s_axis group (opcode in tuser; peer, destination,
//   advertised metric, link metric, current time in tdata) and results leave
//   on the m_axis group. Update and aging items give one result; an advertise
//   item gives one result per route sent to the peer (or one empty result),
//   tlast marks the final transfer of each item.
//   One item is worked at a time. The table is swept one entry at a time,
//   each in two steps (memory read, then evaluate and write back). Aging
//   and advertise items sweep every entry; an update for the own address
//   ends at once, other updates stop at the matching entry or sweep all
//   entries and then try to allocate a new route. The last result is valid
//   in the cycle tready rises again.
//   Results sit in an output register; when the receiver stalls, an
//   advertise sweep holds at the next route until the register drains.
//   Reset clears every entry to free and loads the default timers; the
//   configuration port takes writes whenever the block is idle.
module distance_vector_route_table_core #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dvrt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dvrt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // peer_address, dest_address, advertised_metric, link_metric, now
    input  logic [dvrt_pkg::IN_W-1:0]       i_s_axis_tdata,
    // opcode
    input  logic [dvrt_pkg::IN_USER_W-1:0]  i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // table_changed, route_dest, route_metric, next_deadline
    output logic [dvrt_pkg::OUT_W-1:0]      o_m_axis_tdata,
    // route_valid, deadline_valid
    output logic [dvrt_pkg::USER_W-1:0]     o_m_axis_tuser,
    output logic                            o_m_axis_tlast
);
    import dvrt_pkg::*;

    t_ctrl_cmd w_cmd;
    t_dp_stat  w_stat;

    dvrt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_s_axis_tvalid),
        .o_in_ready(o_s_axis_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    dvrt_datapath #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_op       (i_s_axis_tuser),
        .i_item     (i_s_axis_tdata),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_tvalid   (o_m_axis_tvalid),
        .i_tready   (i_m_axis_tready),
        .o_tdata    (o_m_axis_tdata),
        .o_tuser    (o_m_axis_tuser),
        .o_tlast    (o_m_axis_tlast)
    );

endmodule
